@@ src/sbld_pkg.sv @@
// ----------------------------------------------------------------------------
// sbld_pkg
// Shared types and constants for the STX/BCD-length/LRC deframer: register
// indexes, register reset values, frame layout and the BCD length decode.
// ----------------------------------------------------------------------------
package sbld_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SIZE_W    = 15;   // holds 15*1111
  localparam int unsigned PLEN_W    = 6;

  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PAYLOAD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd3;

  localparam logic [7:0]        START_BYTE_RST  = 8'd2;
  localparam logic [7:0]        END_BYTE_RST    = 8'd3;
  localparam logic [PLEN_W-1:0] MIN_PAYLOAD_RST = 6'd5;
  localparam logic [PLEN_W-1:0] MAX_PAYLOAD_RST = 6'd62;

  // start byte, two length bytes, end byte, LRC byte
  localparam int unsigned FRAME_OVERHEAD = 5;
  localparam int unsigned PAYLOAD_OFFSET = 3;

  // Verdict handed from the frame checker to the sequencer
  typedef struct packed {
    logic              reject;
    logic [PLEN_W-1:0] size;
  } verdict_t;

  // Weigh each nibble as a decimal digit, even when it is above nine
  function automatic logic [SIZE_W-1:0] bcd_weigh(input logic [7:0] hi, input logic [7:0] lo);
    logic [SIZE_W-1:0] thousands;
    logic [SIZE_W-1:0] hundreds;
    logic [SIZE_W-1:0] tens;
    logic [SIZE_W-1:0] units;
    thousands = SIZE_W'(hi[7:4]) * SIZE_W'(1000);
    hundreds  = SIZE_W'(hi[3:0]) * SIZE_W'(100);
    tens      = SIZE_W'(lo[7:4]) * SIZE_W'(10);
    units     = SIZE_W'(lo[3:0]);
    return thousands + hundreds + tens + units;
  endfunction

endpackage

@@ src/stx_bcd_length_lrc_deframer_core.sv @@
// ----------------------------------------------------------------------------
// stx_bcd_length_lrc_deframer_core
// Stores a received buffer one beat per cycle and, on its final beat, checks
// the STX/BCD-length/LRC frame, then plays out the payload or one reject.
// Results are registered: a reject or an empty payload is loaded from the
//   check state; payload bytes follow one per cycle from the store's read
//   port while the output side is ready.
// Throughput: one input beat per cycle while collecting; input is held after
//   the final beat until the result or the last payload byte is loaded.
// Reset: clears only count, state, out_valid and the config registers.
// ----------------------------------------------------------------------------
module stx_bcd_length_lrc_deframer_core #(
  parameter int unsigned MAX_PAYLOAD = 62
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          end_of_buffer_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    payload_byte_o,
  output logic [sbld_pkg::PLEN_W-1:0]   payload_length_o,
  output logic                          status_o,
  output logic                          last_result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sbld_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_data_i
);

  localparam int unsigned DEPTH = MAX_PAYLOAD + sbld_pkg::FRAME_OVERHEAD;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 2);
  localparam int unsigned PW    = sbld_pkg::PLEN_W;

  localparam logic [1:0] ST_COLLECT = 2'd0;
  localparam logic [1:0] ST_CHECK   = 2'd1;
  localparam logic [1:0] ST_EMIT    = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] len_q, len_d;
  logic [PW-1:0]    idx_q, idx_d;
  logic [PW-1:0]    size_q, size_d;

  logic [7:0]    start_byte_q;
  logic [7:0]    end_byte_q;
  logic [PW-1:0] min_payload_q;
  logic [PW-1:0] max_payload_q;

  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic [PW-1:0] out_len_q, out_len_d;
  logic          out_status_q, out_status_d;
  logic          out_last_q, out_last_d;

  logic               in_fire;
  logic               store_en;
  logic               out_free;
  logic               rd_en;
  logic [PW:0]        rd_off;
  logic [AW-1:0]      rd_addr;
  logic [7:0]         rd_data;
  sbld_pkg::verdict_t verdict;

  assign in_ready_o  = (state_q == ST_COLLECT);
  assign in_fire     = in_valid_i && in_ready_o;
  assign store_en    = in_fire && (count_q < CNT_W'(DEPTH));
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q  <= sbld_pkg::START_BYTE_RST;
      end_byte_q    <= sbld_pkg::END_BYTE_RST;
      min_payload_q <= sbld_pkg::MIN_PAYLOAD_RST;
      max_payload_q <= sbld_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sbld_pkg::REG_START_BYTE:  start_byte_q  <= cfg_data_i;
        sbld_pkg::REG_END_BYTE:    end_byte_q    <= cfg_data_i;
        sbld_pkg::REG_MIN_PAYLOAD: min_payload_q <= cfg_data_i[PW-1:0];
        sbld_pkg::REG_MAX_PAYLOAD: max_payload_q <= cfg_data_i[PW-1:0];
        default: ;
      endcase
    end
  end

  sbld_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_en),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (data_byte_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  sbld_frame_check #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .DEPTH       (DEPTH),
    .CNT_W       (CNT_W)
  ) u_check (
    .clk_i         (clk_i),
    .byte_en_i     (store_en),
    .pos_i         (count_q),
    .byte_i        (data_byte_i),
    .len_i         (len_q),
    .start_byte_i  (start_byte_q),
    .end_byte_i    (end_byte_q),
    .min_payload_i (min_payload_q),
    .max_payload_i (max_payload_q),
    .verdict_o     (verdict)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    len_d        = len_q;
    idx_d        = idx_q;
    size_d       = size_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_byte_d   = out_byte_q;
    out_len_d    = out_len_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    rd_en        = 1'b0;
    rd_off       = {1'b0, idx_q} + (PW+1)'(sbld_pkg::PAYLOAD_OFFSET);

    case (state_q)
      ST_COLLECT: begin
        if (in_fire) begin
          // saturate one past the store to flag overflow
          count_d = store_en ? count_q + CNT_W'(1) : CNT_W'(DEPTH + 1);
          if (end_of_buffer_i) begin
            len_d   = count_d;
            count_d = '0;
            state_d = ST_CHECK;
          end
        end
      end

      ST_CHECK: begin
        if (out_free) begin
          if (verdict.reject || (verdict.size == '0)) begin
            out_valid_d  = 1'b1;
            out_byte_d   = 8'd0;
            out_len_d    = '0;
            out_status_d = verdict.reject;
            out_last_d   = 1'b1;
            state_d      = ST_COLLECT;
          end else begin
            idx_d   = '0;
            size_d  = verdict.size;
            rd_en   = 1'b1;
            rd_off  = (PW+1)'(sbld_pkg::PAYLOAD_OFFSET);
            state_d = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        // read data for idx_q is held in the store until the next read
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_byte_d   = rd_data;
          out_len_d    = size_q;
          out_status_d = 1'b0;
          out_last_d   = ({1'b0, idx_q} + (PW+1)'(1)) == {1'b0, size_q};
          if (out_last_d) begin
            state_d = ST_COLLECT;
          end else begin
            idx_d  = idx_q + PW'(1);
            rd_en  = 1'b1;
            rd_off = {1'b0, idx_q} + (PW+1)'(sbld_pkg::PAYLOAD_OFFSET + 1);
          end
        end
      end

      default: begin
        state_d = ST_COLLECT;
      end
    endcase
  end

  assign rd_addr = AW'(rd_off);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q        <= len_d;
    idx_q        <= idx_d;
    size_q       <= size_d;
    out_byte_q   <= out_byte_d;
    out_len_q    <= out_len_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign payload_byte_o   = out_byte_q;
  assign payload_length_o = out_len_q;
  assign status_o         = out_status_q;
  assign last_result_o    = out_last_q;

endmodule

@@ src/sbld_store.sv @@
// ----------------------------------------------------------------------------
// sbld_store
// Byte store of the received buffer: one write port, one read port with a
// registered read that holds its data until the next read.
// ----------------------------------------------------------------------------
module sbld_store #(
  parameter int unsigned DEPTH = 67,
  parameter int unsigned AW    = 7
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/sbld_frame_check.sv @@
// ----------------------------------------------------------------------------
// sbld_frame_check
// Watches stored bytes as they arrive: keeps the start byte, decodes the BCD
// length, picks up the byte after the payload and folds the LRC. Gives the
// frame verdict against the current register values.
// ----------------------------------------------------------------------------
module sbld_frame_check #(
  parameter int unsigned MAX_PAYLOAD = 62,
  parameter int unsigned DEPTH       = 67,
  parameter int unsigned CNT_W       = 7
) (
  input  logic                       clk_i,
  input  logic                       byte_en_i,
  input  logic [CNT_W-1:0]           pos_i,
  input  logic [7:0]                 byte_i,
  input  logic [CNT_W-1:0]           len_i,
  input  logic [7:0]                 start_byte_i,
  input  logic [7:0]                 end_byte_i,
  input  logic [sbld_pkg::PLEN_W-1:0] min_payload_i,
  input  logic [sbld_pkg::PLEN_W-1:0] max_payload_i,
  output sbld_pkg::verdict_t         verdict_o
);

  localparam logic [15:0] MAXP_LIM = 16'(MAX_PAYLOAD);
  localparam logic [15:0] DEPTH_W  = 16'(DEPTH);
  localparam logic [15:0] OVH      = 16'(sbld_pkg::FRAME_OVERHEAD);

  logic [7:0]                  first_q, first_d;
  logic [7:0]                  hi_q, hi_d;
  logic [7:0]                  endb_q, endb_d;
  logic [7:0]                  lrc_q, lrc_d;
  logic [sbld_pkg::SIZE_W-1:0] size_q, size_d;

  logic [15:0] pos16;
  logic [15:0] size16;
  logic [15:0] len16;
  logic [15:0] min16;
  logic [15:0] max16;
  logic [15:0] maxp16;

  assign pos16  = 16'(pos_i);
  assign size16 = 16'(size_q);

  always_comb begin
    first_d = first_q;
    hi_d    = hi_q;
    endb_d  = endb_q;
    lrc_d   = lrc_q;
    size_d  = size_q;
    if (byte_en_i) begin
      if (pos16 == 16'd0) begin
        first_d = byte_i;
        lrc_d   = 8'd0;
      end else if (pos16 == 16'd1) begin
        hi_d  = byte_i;
        lrc_d = lrc_q ^ byte_i;
      end else if (pos16 == 16'd2) begin
        size_d = sbld_pkg::bcd_weigh(hi_q, byte_i);
        lrc_d  = lrc_q ^ byte_i;
      end else begin
        // fold bytes up to and including the LRC byte only
        if (pos16 <= size16 + 16'd4) begin
          lrc_d = lrc_q ^ byte_i;
        end
        if (pos16 == size16 + 16'd3) begin
          endb_d = byte_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    hi_q    <= hi_d;
    endb_q  <= endb_d;
    lrc_q   <= lrc_d;
    size_q  <= size_d;
  end

  assign len16  = 16'(len_i);
  assign min16  = 16'(min_payload_i);
  assign max16  = 16'(max_payload_i);
  assign maxp16 = (max16 > MAXP_LIM) ? MAXP_LIM : max16;

  always_comb begin
    verdict_o.reject = (len16 > DEPTH_W)
                    || (len16 < min16 + OVH)
                    || (len16 > maxp16 + OVH)
                    || (first_q != start_byte_i)
                    || (size16 < min16)
                    || (size16 > maxp16)
                    || (size16 + OVH > len16)
                    || (endb_q != end_byte_i)
                    || (lrc_q != 8'd0);
    verdict_o.size   = size_q[sbld_pkg::PLEN_W-1:0];
  end

endmodule
